>>> design/spectral_flux_transient_detector_defines.svh
// Assertion macros shared by the spectral flux detector checker.
// Include this header with the bare file name; it depends on nothing else.
`ifndef SPECTRAL_FLUX_TRANSIENT_DETECTOR_DEFINES_SVH
`define SPECTRAL_FLUX_TRANSIENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, masked while reset is high
`define SFD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is high
`define SFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define SFD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sfd_pkg.sv
// Shared types and constants of the spectral flux transient detector.
// No dependencies; used by the divider, the bin memory users and the top level.
package sfd_pkg;

  localparam int MAG_W     = 24;
  localparam int SUM_W     = 35;
  localparam int GAIN_W    = 16;
  localparam int STR_W     = 16;
  localparam int PROD_W    = SUM_W + GAIN_W;
  localparam int NUM_W     = PROD_W + 8;
  localparam int STEP_W    = 4;
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
  localparam logic [SUM_W-1:0]  SUM_MAX    = '1;
  localparam logic [STR_W-1:0]  STR_MAX    = '1;

  // Item kinds carried in s_tuser
  localparam logic KIND_BIN   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_SAT,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic             ch;
    logic [SUM_W-1:0] flux;
    logic [SUM_W-1:0] energy;
  } div_req_t;

  typedef struct packed {
    logic             ch;
    logic [STR_W-1:0] strength;
  } div_res_t;

endpackage

>>> design/sfd_ram.sv
// Simple dual-port memory holding previous-frame bin magnitudes.
// One write and one read port, read data registered; no package use.
module sfd_ram #(
  parameter int DEPTH  = 2050,
  parameter int ADDR_W = 12,
  parameter int WIDTH  = 24
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, returns old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/sfd_div.sv
// Frame-end divider: strength = min(65535, flux * gain * 256 / energy).
// Multiply once, check saturation, then one quotient bit per cycle. Uses sfd_pkg.
module sfd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  sfd_pkg::div_req_t            req,
  input  logic [sfd_pkg::GAIN_W-1:0]   gain,
  output logic                         busy,
  output logic                         done,
  output sfd_pkg::div_res_t            res,
  input  logic                         ack
);

  sfd_pkg::div_state_t state, state_next;

  logic                          ch;
  logic [sfd_pkg::SUM_W-1:0]     flux;
  logic [sfd_pkg::SUM_W-1:0]     energy;
  logic [sfd_pkg::NUM_W-1:0]     num;
  logic [sfd_pkg::PROD_W-1:0]    dsr;
  logic [sfd_pkg::STR_W-1:0]     quo;
  logic [sfd_pkg::STEP_W-1:0]    step;
  logic [sfd_pkg::NUM_W-1:0]     sat_lim;
  logic                          sat_hit;
  logic                          bit_hit;

  assign sat_lim = {{(sfd_pkg::NUM_W - sfd_pkg::SUM_W - sfd_pkg::STR_W){1'b0}},
                    energy, {sfd_pkg::STR_W{1'b0}}};
  assign sat_hit = (num >= sat_lim);
  assign bit_hit = (num >= {{(sfd_pkg::NUM_W - sfd_pkg::PROD_W){1'b0}}, dsr});

  assign busy = (state != sfd_pkg::DIV_IDLE);
  assign done = (state == sfd_pkg::DIV_DONE);
  assign res  = '{ch: ch, strength: quo};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sfd_pkg::DIV_IDLE: if (start) state_next = sfd_pkg::DIV_MUL;
      sfd_pkg::DIV_MUL:  state_next = sfd_pkg::DIV_SAT;
      sfd_pkg::DIV_SAT: begin
        if (energy == '0 || sat_hit) begin
          state_next = sfd_pkg::DIV_DONE;
        end else begin
          state_next = sfd_pkg::DIV_RUN;
        end
      end
      sfd_pkg::DIV_RUN:  if (step == '0) state_next = sfd_pkg::DIV_DONE;
      sfd_pkg::DIV_DONE: if (ack) state_next = sfd_pkg::DIV_IDLE;
      default:           state_next = sfd_pkg::DIV_IDLE;
    endcase
  end

  // Datapath: latch operands, multiply, then restoring division
  always_ff @(posedge clk) begin
    case (state)
      sfd_pkg::DIV_IDLE: begin
        if (start) begin
          ch     <= req.ch;
          flux   <= req.flux;
          energy <= req.energy;
        end
      end
      sfd_pkg::DIV_MUL: begin
        num <= {sfd_pkg::PROD_W'(flux) * sfd_pkg::PROD_W'(gain), 8'd0};
      end
      sfd_pkg::DIV_SAT: begin
        if (energy == '0) begin
          quo <= '0;
        end else if (sat_hit) begin
          quo <= sfd_pkg::STR_MAX;
        end else begin
          quo  <= '0;
          dsr  <= {{(sfd_pkg::PROD_W - sfd_pkg::SUM_W - sfd_pkg::STR_W + 1){1'b0}},
                   energy, {(sfd_pkg::STR_W - 1){1'b0}}};
          step <= sfd_pkg::STEP_W'(sfd_pkg::STR_W - 1);
        end
      end
      sfd_pkg::DIV_RUN: begin
        if (bit_hit) begin
          num <= num - {{(sfd_pkg::NUM_W - sfd_pkg::PROD_W){1'b0}}, dsr};
        end
        quo  <= {quo[sfd_pkg::STR_W-2:0], bit_hit};
        dsr  <= dsr >> 1;
        step <= step - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/spectral_flux_transient_detector.sv
// Spectral flux transient detector: s_ channel takes bins and clear items,
// m_ channel returns one strength per completed frame, cfg channel sets the gain.
// Uses sfd_pkg, sfd_ram and sfd_div.
//
// Usage:
//   s_ beats carry one bin magnitude each (s_tuser = 0) or a clear (s_tuser = 1).
//   s_tlast marks a frame's final bin and produces one m_ beat with the channel
//   and min(65535, flux * gain * 256 / energy), or 0 when the energy is zero.
//   Bins stream at one per cycle bar a held-off final bin: each is read from the
//   bin memory when taken and written back with the updated magnitude in the
//   cycle after, with forwarding when consecutive bins hit the same entry. A
//   result passes the divider's multiply and saturation states, its run state
//   (one quotient bit a cycle) unless the energy is zero or the ratio saturates,
//   and the output register. The division overlaps the next frame's bins; only
//   a final bin that arrives while the previous division or its result is still
//   pending is held off (s_tready low for that beat only).
//   Reset clears the previous-frame flags, bin counter, sums, divider and the
//   output register; the gain returns to 1.0 (256). The bin memory is not
//   cleared; entries are used only once a frame of that channel has ended.
//   When m_tready is low the result holds in the output register and the
//   divider holds its next result, while bins keep flowing.
//   cfg_ready is always high; write the gain only while the block is idle.
module spectral_flux_transient_detector #(
  parameter int NUM_BINS = 1025,
  parameter int CHANNELS = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sfd_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] channel, [24:1] magnitude
  input  logic                            s_tuser,   // [0] kind
  input  logic                            s_tlast,   // last_bin
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sfd_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] out_channel, [16:1] transient_strength
  // gain write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfd_pkg::GAIN_W-1:0]      cfg_data
);

  localparam int DEPTH  = CHANNELS * NUM_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(NUM_BINS + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [sfd_pkg::SUM_W-1:0] sat_add(
    input logic [sfd_pkg::SUM_W-1:0] a,
    input logic [sfd_pkg::SUM_W-1:0] b
  );
    logic [sfd_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[sfd_pkg::SUM_W] ? sfd_pkg::SUM_MAX : s[sfd_pkg::SUM_W-1:0];
  endfunction

  // Input fields
  logic                        in_ch;
  logic [sfd_pkg::MAG_W-1:0]   in_mag;
  logic                        accept;
  logic                        in_clear;
  logic                        ch_ok;
  logic [CH_W-1:0]             ch_idx;
  logic                        in_range;
  logic [ADDR_W-1:0]           rd_slot;

  // Stage 1 state
  logic [sfd_pkg::GAIN_W-1:0]  flux_gain;
  logic [CHANNELS-1:0]         has_prev;
  logic [CNT_W-1:0]            bin_cnt;

  // Stage 2 registers
  logic                        s2_valid;
  logic                        s2_clear;
  logic                        s2_store;
  logic                        s2_emit;
  logic                        s2_use_prev;
  logic                        s2_fwd;
  logic [sfd_pkg::MAG_W-1:0]   s2_fwd_mag;
  logic [ADDR_W-1:0]           s2_slot;
  logic [sfd_pkg::MAG_W-1:0]   s2_mag;
  logic                        s2_ch;

  logic [sfd_pkg::MAG_W-1:0]   mem_rdata;
  logic [sfd_pkg::MAG_W-1:0]   prev_mag;
  logic [sfd_pkg::MAG_W-1:0]   before_mag;
  logic [sfd_pkg::MAG_W-1:0]   diff;
  logic [sfd_pkg::SUM_W-1:0]   flux_sum;
  logic [sfd_pkg::SUM_W-1:0]   energy_sum;
  logic [sfd_pkg::SUM_W-1:0]   flux_next;
  logic [sfd_pkg::SUM_W-1:0]   energy_next;
  logic                        mem_we;

  // Divider and output
  sfd_pkg::div_req_t           div_req;
  sfd_pkg::div_res_t           div_res;
  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic                        div_ack;
  logic                        out_ch;
  logic [sfd_pkg::STR_W-1:0]   out_str;

  assign in_ch    = s_tdata[0];
  assign in_mag   = s_tdata[sfd_pkg::MAG_W:1];
  assign in_clear = (s_tuser == sfd_pkg::KIND_CLEAR);
  assign ch_ok    = (CHANNELS > 1) || (in_ch == 1'b0);
  assign ch_idx   = CH_W'(in_ch);
  assign in_range = (bin_cnt < CNT_W'(NUM_BINS));
  assign rd_slot  = in_range ? ((in_ch ? ADDR_W'(NUM_BINS) : '0) + ADDR_W'(bin_cnt)) : '0;

  // Hold off a final bin while a division or its result is still pending
  assign s_tready  = !(s_tlast && (div_busy || (s2_valid && s2_emit)));
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Gain register
  always_ff @(posedge clk) begin
    if (rst) begin
      flux_gain <= sfd_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      flux_gain <= cfg_data;
    end
  end

  // Stage 1: flags and bin counter advance as each beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      has_prev <= '0;
      bin_cnt  <= '0;
    end else if (accept) begin
      if (in_clear) begin
        has_prev <= '0;
        bin_cnt  <= '0;
      end else if (ch_ok) begin
        if (s_tlast) begin
          has_prev[ch_idx] <= 1'b1;
          bin_cnt          <= '0;
        end else if (in_range) begin
          bin_cnt <= bin_cnt + 1'b1;
        end
      end
    end
  end

  // Stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= accept;
    end
  end

  // Stage 2 payload, with forwarding of the write that overlaps this read
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_clear    <= in_clear;
      s2_store    <= !in_clear && ch_ok && in_range;
      s2_emit     <= !in_clear && ch_ok && s_tlast;
      s2_use_prev <= has_prev[ch_idx];
      s2_fwd      <= mem_we && (s2_slot == rd_slot);
      s2_fwd_mag  <= s2_mag;
      s2_slot     <= rd_slot;
      s2_mag      <= in_mag;
      s2_ch       <= in_ch;
    end
  end

  sfd_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .WIDTH  (sfd_pkg::MAG_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s2_slot),
    .wdata (s2_mag),
    .raddr (rd_slot),
    .rdata (mem_rdata)
  );

  // Compare with previous frame and accumulate
  always_comb begin
    mem_we      = s2_valid && s2_store;
    prev_mag    = s2_fwd ? s2_fwd_mag : mem_rdata;
    before_mag  = s2_use_prev ? prev_mag : s2_mag;
    diff        = (s2_mag > before_mag) ? (s2_mag - before_mag) : '0;
    flux_next   = flux_sum;
    energy_next = energy_sum;
    if (s2_store) begin
      flux_next   = sat_add(flux_sum, sfd_pkg::SUM_W'(diff));
      energy_next = sat_add(energy_sum, sfd_pkg::SUM_W'(s2_mag));
    end
  end

  // Sums: restart after a frame end or a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      flux_sum   <= '0;
      energy_sum <= '0;
    end else if (s2_valid) begin
      if (s2_clear || s2_emit) begin
        flux_sum   <= '0;
        energy_sum <= '0;
      end else begin
        flux_sum   <= flux_next;
        energy_sum <= energy_next;
      end
    end
  end

  assign div_start = s2_valid && s2_emit;
  assign div_req   = '{ch: s2_ch, flux: flux_next, energy: energy_next};
  assign div_ack   = div_done && (!m_tvalid || m_tready);

  sfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .gain  (flux_gain),
    .busy  (div_busy),
    .done  (div_done),
    .res   (div_res),
    .ack   (div_ack)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (div_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ack) begin
      out_ch  <= div_res.ch;
      out_str <= div_res.strength;
    end
  end

  assign m_tdata = {{(sfd_pkg::M_TDATA_W - sfd_pkg::STR_W - 1){1'b0}}, out_str, out_ch};

endmodule

>>> design/sfd_checker.sv
// Port-level checker for the spectral flux transient detector, bound to the top.
// Depends on spectral_flux_transient_detector_defines.svh for the assertion macros.
`include "spectral_flux_transient_detector_defines.svh"

module sfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Reset empties the output register
  `SFD_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, rst, !m_tvalid, "result valid after reset")

  // A stalled result holds
  `SFD_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // Only final bins are ever held off
  `SFD_ASSERT_NOW(a_stall_last, clk, rst, !s_tready, s_tlast, "non-final beat stalled")

  // A result never appears the cycle right after its final bin
  `SFD_ASSERT_NOW(a_min_latency, clk, rst, $rose(m_tvalid), !$past(s_tvalid && s_tready && s_tlast), "result too early")

endmodule

bind spectral_flux_transient_detector sfd_checker u_sfd_checker (.*);
